// File: sv/mcpp_pkg.sv
// ----------------------------------------------------------------------------
// mcpp_pkg
// Shared types and codes for the MQTT control packet parser: parse phases,
// record kinds, error codes, and the parser state and result structures.
// ----------------------------------------------------------------------------
package mcpp_pkg;

	// Parse phases.
	localparam logic [4:0] PH_START     = 5'd0;
	localparam logic [4:0] PH_LEN       = 5'd1;
	localparam logic [4:0] PH_DONE      = 5'd2;
	localparam logic [4:0] PH_C_PNL_HI  = 5'd3;
	localparam logic [4:0] PH_C_PNL_LO  = 5'd4;
	localparam logic [4:0] PH_C_PNAME   = 5'd5;
	localparam logic [4:0] PH_C_LEVEL   = 5'd6;
	localparam logic [4:0] PH_C_FLAGS   = 5'd7;
	localparam logic [4:0] PH_C_KA_HI   = 5'd8;
	localparam logic [4:0] PH_C_KA_LO   = 5'd9;
	localparam logic [4:0] PH_C_CIL_HI  = 5'd10;
	localparam logic [4:0] PH_C_CIL_LO  = 5'd11;
	localparam logic [4:0] PH_C_CID     = 5'd12;
	localparam logic [4:0] PH_CA_FLAGS  = 5'd13;
	localparam logic [4:0] PH_CA_CODE   = 5'd14;
	localparam logic [4:0] PH_P_TL_HI   = 5'd15;
	localparam logic [4:0] PH_P_TL_LO   = 5'd16;
	localparam logic [4:0] PH_P_TOPIC   = 5'd17;
	localparam logic [4:0] PH_PID_HI    = 5'd18;
	localparam logic [4:0] PH_PID_LO    = 5'd19;
	localparam logic [4:0] PH_S_TL_HI   = 5'd20;
	localparam logic [4:0] PH_S_TL_LO   = 5'd21;
	localparam logic [4:0] PH_S_TOPIC   = 5'd22;
	localparam logic [4:0] PH_S_QOS     = 5'd23;
	localparam logic [4:0] PH_SA_QOS    = 5'd24;
	localparam logic [4:0] PH_U_TL_HI   = 5'd25;
	localparam logic [4:0] PH_U_TL_LO   = 5'd26;
	localparam logic [4:0] PH_U_TOPIC   = 5'd27;
	localparam logic [4:0] PH_ERR_SKIP  = 5'd28;

	// Record kinds.
	localparam logic [3:0] K_NONE   = 4'd0;
	localparam logic [3:0] K_TYPE   = 4'd1;
	localparam logic [3:0] K_LENGTH = 4'd2;
	localparam logic [3:0] K_HEADER = 4'd3;
	localparam logic [3:0] K_STRING = 4'd4;
	localparam logic [3:0] K_PID    = 4'd5;
	localparam logic [3:0] K_QOS    = 4'd6;
	localparam logic [3:0] K_ERROR  = 4'd7;

	// Error codes carried in the value of an error record.
	localparam logic [27:0] ERR_LONG  = 28'd1;
	localparam logic [27:0] ERR_TYPE  = 28'd2;
	localparam logic [27:0] ERR_TRUNC = 28'd3;

	// Packet types that steer the parse.
	localparam logic [3:0] PT_CONNECT     = 4'd1;
	localparam logic [3:0] PT_CONNACK     = 4'd2;
	localparam logic [3:0] PT_PUBLISH     = 4'd3;
	localparam logic [3:0] PT_PUBACK      = 4'd4;
	localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
	localparam logic [3:0] PT_SUBACK      = 4'd9;
	localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
	localparam logic [3:0] PT_UNSUBACK    = 4'd11;
	localparam logic [3:0] PT_RESERVED_LO = 4'd0;
	localparam logic [3:0] PT_RESERVED_HI = 4'd15;

	// Parser state carried from byte to byte.
	typedef struct packed {
		logic [4:0]  phase;
		logic [3:0]  ptype;
		logic [27:0] len_acc;
		logic [2:0]  len_cnt;
		logic [15:0] str_left;
		logic [7:0]  hi_byte;
	} mcpp_state_t;

	// One output record, with a flag telling whether it is produced.
	typedef struct packed {
		logic        emit;
		logic [3:0]  kind;
		logic [27:0] value;
		logic        pend;
	} mcpp_result_t;

endpackage

// File: sv/mcpp_step.sv
// ----------------------------------------------------------------------------
// mcpp_step
// Combinational parser step: given the current parser state and one packet
// byte, produces the next state and at most one output record.
// ----------------------------------------------------------------------------
module mcpp_step import mcpp_pkg::*; (
	input  mcpp_state_t  cur,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	input  logic         emit_str,
	output mcpp_state_t  nxt,
	output mcpp_result_t res
);

	// First phase of the body for each packet type.
	function automatic logic [4:0] body_start(input logic [3:0] t);
		logic [4:0] ph;
		if (t == PT_CONNECT)
			ph = PH_C_PNL_HI;
		else if (t == PT_CONNACK)
			ph = PH_CA_FLAGS;
		else if (t == PT_PUBLISH)
			ph = PH_P_TL_HI;
		else if (t >= PT_PUBACK && t <= PT_UNSUBACK)
			ph = PH_PID_HI;
		else
			ph = PH_DONE;
		return ph;
	endfunction

	// Phase that follows a finished string.
	function automatic logic [4:0] after_string(input logic [4:0] ph);
		logic [4:0] r;
		case (ph)
			PH_C_PNAME: r = PH_C_LEVEL;
			PH_S_TOPIC: r = PH_S_QOS;
			PH_U_TOPIC: r = PH_U_TL_HI;
			default:    r = PH_DONE;
		endcase
		return r;
	endfunction

	// Phases at which a packet may legally end.
	function automatic logic end_ok(input logic [4:0] ph);
		return ph == PH_DONE || ph == PH_S_TL_HI || ph == PH_SA_QOS ||
		       ph == PH_U_TL_HI || ph == PH_ERR_SKIP;
	endfunction

	logic [15:0] w16;
	logic [27:0] len_add;
	logic [15:0] str_dec;
	logic [4:0]  next_ph;
	logic [4:0]  ph_inc;
	logic [3:0]  kind;
	logic [27:0] val;
	logic        have;

	assign w16     = {cur.hi_byte, data_byte};
	assign str_dec = cur.str_left - 16'd1;
	assign ph_inc  = cur.phase + 5'd1;

	// Seven-bit length group placed by its position.
	always_comb begin
		case (cur.len_cnt[1:0])
			2'd0:    len_add = {21'd0, data_byte[6:0]};
			2'd1:    len_add = {14'd0, data_byte[6:0], 7'd0};
			2'd2:    len_add = {7'd0, data_byte[6:0], 14'd0};
			default: len_add = {data_byte[6:0], 21'd0};
		endcase
	end

	// Phase decode and record selection.
	always_comb begin
		nxt     = cur;
		kind    = K_NONE;
		val     = '0;
		have    = 1'b0;
		next_ph = cur.phase;
		case (cur.phase)
			PH_START: begin
				nxt.ptype   = data_byte[7:4];
				nxt.len_acc = '0;
				nxt.len_cnt = '0;
				have        = 1'b1;
				if (data_byte[7:4] == PT_RESERVED_LO || data_byte[7:4] == PT_RESERVED_HI) begin
					kind    = K_ERROR;
					val     = ERR_TYPE;
					next_ph = PH_ERR_SKIP;
				end else begin
					kind    = K_TYPE;
					val     = {24'd0, data_byte[7:4]};
					next_ph = PH_LEN;
				end
			end
			PH_LEN: begin
				if (cur.len_cnt < 3'd4) begin
					nxt.len_acc = cur.len_acc + len_add;
					nxt.len_cnt = cur.len_cnt + 3'd1;
				end
				if (data_byte[7]) begin
					if (nxt.len_cnt >= 3'd4) begin
						have    = 1'b1;
						kind    = K_ERROR;
						val     = ERR_LONG;
						next_ph = PH_ERR_SKIP;
					end
				end else begin
					have    = 1'b1;
					kind    = K_LENGTH;
					val     = nxt.len_acc;
					next_ph = body_start(cur.ptype);
				end
			end
			PH_C_PNL_HI, PH_C_KA_HI, PH_C_CIL_HI, PH_P_TL_HI, PH_PID_HI,
			PH_S_TL_HI, PH_U_TL_HI: begin
				nxt.hi_byte = data_byte;
				next_ph     = ph_inc;
			end
			PH_C_PNL_LO, PH_C_CIL_LO, PH_P_TL_LO, PH_S_TL_LO, PH_U_TL_LO: begin
				have         = 1'b1;
				kind         = K_HEADER;
				val          = {12'd0, w16};
				nxt.str_left = w16;
				next_ph      = (w16 == 16'd0) ? after_string(ph_inc) : ph_inc;
			end
			PH_C_PNAME, PH_C_CID, PH_P_TOPIC, PH_S_TOPIC, PH_U_TOPIC: begin
				if (emit_str) begin
					have = 1'b1;
					kind = K_STRING;
					val  = {20'd0, data_byte};
				end
				nxt.str_left = str_dec;
				if (str_dec == 16'd0)
					next_ph = after_string(cur.phase);
			end
			PH_C_LEVEL, PH_C_FLAGS: begin
				have    = 1'b1;
				kind    = K_HEADER;
				val     = {20'd0, data_byte};
				next_ph = ph_inc;
			end
			PH_C_KA_LO: begin
				have    = 1'b1;
				kind    = K_HEADER;
				val     = {12'd0, w16};
				next_ph = PH_C_CIL_HI;
			end
			PH_CA_FLAGS: begin
				have    = 1'b1;
				kind    = K_HEADER;
				val     = {27'd0, data_byte[0]};
				next_ph = PH_CA_CODE;
			end
			PH_CA_CODE: begin
				have    = 1'b1;
				kind    = K_HEADER;
				val     = {20'd0, data_byte};
				next_ph = PH_DONE;
			end
			PH_PID_LO: begin
				have = 1'b1;
				kind = K_PID;
				val  = {12'd0, w16};
				if (cur.ptype == PT_SUBSCRIBE)
					next_ph = PH_S_TL_HI;
				else if (cur.ptype == PT_SUBACK)
					next_ph = PH_SA_QOS;
				else if (cur.ptype == PT_UNSUBSCRIBE)
					next_ph = PH_U_TL_HI;
				else
					next_ph = PH_DONE;
			end
			PH_S_QOS: begin
				have    = 1'b1;
				kind    = K_QOS;
				val     = {20'd0, data_byte};
				next_ph = PH_S_TL_HI;
			end
			PH_SA_QOS: begin
				have    = 1'b1;
				kind    = K_QOS;
				val     = {20'd0, data_byte};
				next_ph = PH_SA_QOS;
			end
			PH_ERR_SKIP: begin
				next_ph = PH_ERR_SKIP;
			end
			default: begin
				next_ph = PH_DONE;
			end
		endcase
		nxt.phase = next_ph;

		// The final byte always yields a record and clears the parse.
		res.pend = last_byte;
		if (last_byte) begin
			res.emit = 1'b1;
			if (!end_ok(next_ph)) begin
				res.kind  = K_ERROR;
				res.value = ERR_TRUNC;
			end else if (!have) begin
				res.kind  = K_NONE;
				res.value = '0;
			end else begin
				res.kind  = kind;
				res.value = val;
			end
			nxt       = '0;
			nxt.phase = PH_START;
		end else begin
			res.emit  = have;
			res.kind  = kind;
			res.value = val;
		end
	end

endmodule

// File: sv/mqtt_control_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// mqtt_control_packet_parser_unit
// Parses the bytes of one MQTT 3.1.1 control packet and emits one record per
// decoded field: type, remaining length, header fields, string bytes, packet
// ids, QoS values and error codes.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   data_byte, last_byte
// out       output     out_valid / out_ready field_kind, field_value, payload_end
// cfg       input      cfg_valid / cfg_ready emit_string_bytes
//
// One byte is taken per cycle while in_ready is high. A byte is registered at its
// transfer and runs through the parser step while it sits in the input register;
// its record (if any) is loaded into the output register when the byte advances,
// which it does once the output register is free.
// The parser state register is the only loop; it updates once per byte.
// A stalled output holds its record while one further byte waits in the input
// register; input ready drops only when both are full.
// Reset clears the parser to the start of a packet and sets string-byte
// emission on. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module mqtt_control_packet_parser_unit import mcpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  field_kind,
	output logic [27:0] field_value,
	output logic        payload_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        emit_string_bytes
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         emit_str_q;
	mcpp_state_t  state_q;
	mcpp_state_t  state_nxt;
	mcpp_result_t res;
	logic         out_valid_q;
	logic [3:0]   kind_q;
	logic [27:0]  value_q;
	logic         pend_q;
	logic         advance;

	// The byte in the input register moves on when the output register is free.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			emit_str_q <= 1'b1;
		else if (cfg_valid)
			emit_str_q <= emit_string_bytes;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Parser step.
	mcpp_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.emit_str  (emit_str_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_START, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && res.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			kind_q  <= res.kind;
			value_q <= res.value;
			pend_q  <= res.pend;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_kind  = kind_q;
	assign field_value = value_q;
	assign payload_end = pend_q;

	// The phase never leaves the defined range.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase <= PH_ERR_SKIP)
		else $error("parse phase out of range");

	// A final byte returns the parser to the start of a packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.phase == PH_START)
		else $error("parser not cleared after final byte");

	// Inside a string there is always at least one byte left.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_C_PNAME || state_q.phase == PH_C_CID ||
		 state_q.phase == PH_P_TOPIC || state_q.phase == PH_S_TOPIC ||
		 state_q.phase == PH_U_TOPIC) |-> state_q.str_left != 16'd0)
		else $error("string phase with no bytes left");

	// A final byte always produces a record marked as the payload end.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid_q && pend_q)
		else $error("final byte gave no end record");

endmodule
